// ===== rtl/core/bldc_pkg.sv =====
// shared types and constants for the six-step bldc speed controller
// no dependencies
package bldc_pkg;

  localparam int unsigned TimerHz     = 1000000;
  localparam int unsigned PwmMax      = 255;
  localparam int unsigned WarmupTicks = 5;
  localparam logic [31:0] SpeedNum    = 32'(64'd10 * 64'(TimerHz));

  localparam logic [2:0] CFG_KP      = 3'd0;
  localparam logic [2:0] CFG_KI      = 3'd1;
  localparam logic [2:0] CFG_TARGET  = 3'd2;
  localparam logic [2:0] CFG_REVERSE = 3'd3;
  localparam logic [2:0] CFG_POWER   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMM,
    ST_ERR,
    ST_INTEG,
    ST_KP,
    ST_KI_LO,
    ST_KI_HI,
    ST_DUTY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic comm_upd;
    logic tick_upd;
    logic err_calc;
    logic integ_calc;
    logic kp_mul;
    logic ki_lo_mul;
    logic ki_hi_mul;
    logic duty_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic moved;
    logic warm;
    logic div_done;
  } status_t;

  // phases driven with pwm and enabled per commutation step
  function automatic logic [2:0] step_drive(input logic [2:0] s);
    case (s)
      3'd0: step_drive = 3'b001;
      3'd1: step_drive = 3'b010;
      3'd2: step_drive = 3'b010;
      3'd3: step_drive = 3'b100;
      3'd4: step_drive = 3'b100;
      3'd5: step_drive = 3'b001;
      default: step_drive = 3'b000;
    endcase
  endfunction

  function automatic logic [2:0] step_enable(input logic [2:0] s);
    case (s)
      3'd0: step_enable = 3'b101;
      3'd1: step_enable = 3'b110;
      3'd2: step_enable = 3'b011;
      3'd3: step_enable = 3'b101;
      3'd4: step_enable = 3'b110;
      3'd5: step_enable = 3'b011;
      default: step_enable = 3'b000;
    endcase
  endfunction

endpackage

// ===== rtl/core/bldc_ctrl.sv =====
// controller state machine sequencing commutation and pi updates
// depends on bldc_pkg
module bldc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_free,
  input  bldc_pkg::status_t sts,
  output bldc_pkg::cmd_t    cmd
);

  bldc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bldc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bldc_pkg::ST_IDLE:  if (in_valid) state_nxt = bldc_pkg::ST_DIV;
      bldc_pkg::ST_DIV: begin
        if (sts.is_tick) state_nxt = sts.warm ? bldc_pkg::ST_ERR : bldc_pkg::ST_OUT;
        else if (!sts.moved || sts.div_done) state_nxt = bldc_pkg::ST_COMM;
      end
      bldc_pkg::ST_COMM:  state_nxt = bldc_pkg::ST_OUT;
      bldc_pkg::ST_ERR:   state_nxt = bldc_pkg::ST_INTEG;
      bldc_pkg::ST_INTEG: state_nxt = bldc_pkg::ST_KP;
      bldc_pkg::ST_KP:    state_nxt = bldc_pkg::ST_KI_LO;
      bldc_pkg::ST_KI_LO: state_nxt = bldc_pkg::ST_KI_HI;
      bldc_pkg::ST_KI_HI: state_nxt = bldc_pkg::ST_DUTY;
      bldc_pkg::ST_DUTY:  state_nxt = bldc_pkg::ST_OUT;
      bldc_pkg::ST_OUT:   if (out_free) state_nxt = bldc_pkg::ST_IDLE;
      default:            state_nxt = bldc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      bldc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      bldc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.is_tick) cmd.tick_upd = 1'b1;
      end
      bldc_pkg::ST_COMM:  cmd.comm_upd = 1'b1;
      bldc_pkg::ST_ERR:   cmd.err_calc = 1'b1;
      bldc_pkg::ST_INTEG: cmd.integ_calc = 1'b1;
      bldc_pkg::ST_KP:    cmd.kp_mul = 1'b1;
      bldc_pkg::ST_KI_LO: cmd.ki_lo_mul = 1'b1;
      bldc_pkg::ST_KI_HI: cmd.ki_hi_mul = 1'b1;
      bldc_pkg::ST_DUTY:  cmd.duty_calc = 1'b1;
      bldc_pkg::ST_OUT:   cmd.out_load = out_free;
      default: ;
    endcase
    cmd.div_start = cmd.load;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bldc_pkg::ST_IDLE) |-> in_stall)
    else $error("accepting while busy");
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == bldc_pkg::ST_DIV))
    else $error("load did not start work");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == bldc_pkg::ST_IDLE))
    else $error("result not retired");

endmodule

// ===== rtl/core/bldc_dp.sv =====
// datapath: state registers, radix-2 speed divider, shared 32x32 multiplier
// depends on bldc_pkg
module bldc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bldc_pkg::cmd_t    cmd,
  output bldc_pkg::status_t sts,
  input  logic              in_op,
  input  logic [2:0]        in_hall_sector,
  input  logic [31:0]       in_time_now,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic [7:0]        res_pwm,
  output logic [2:0]        res_drive,
  output logic [2:0]        res_en,
  output logic [15:0]       res_speed,
  output logic [15:0]       res_duty
);

  logic [31:0] kp_r, ki_r;
  logic [15:0] target_r;
  logic        rev_r, pwr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 32'd77750; ki_r <= 32'd211120; target_r <= 16'd10000;
      rev_r <= 1'b0; pwr_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bldc_pkg::CFG_KP:      kp_r <= cfg_data;
        bldc_pkg::CFG_KI:      ki_r <= cfg_data;
        bldc_pkg::CFG_TARGET:  target_r <= cfg_data[15:0];
        bldc_pkg::CFG_REVERSE: rev_r <= cfg_data[0];
        bldc_pkg::CFG_POWER:   pwr_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic        op_r;
  logic [2:0]  sec_r, prev_sec_r;
  logic [31:0] now_r, prev_stime_r, prev_ctime_r, dt_r;
  logic [15:0] speed_r, duty_r;
  logic signed [47:0] integ_r;
  logic [2:0]  warm_r;
  logic        moved_r;

  // divider: 10*TIMER_HZ / elapsed, one quotient bit per cycle
  logic [31:0] dvs_r, quo_r, rem_r;
  logic [5:0]  dcnt_r;
  logic [32:0] rem_sh;
  logic [2:0]  sec_mod, diff;
  logic [3:0]  diff_raw;
  assign sec_mod  = (in_hall_sector >= 3'd6) ? in_hall_sector - 3'd6 : in_hall_sector;
  assign diff_raw = {1'b0, sec_mod} + 4'd6 - {1'b0, prev_sec_r};
  assign diff     = (diff_raw >= 4'd6) ? 3'(diff_raw - 4'd6) : diff_raw[2:0];
  assign rem_sh   = {rem_r, bldc_pkg::SpeedNum[5'(dcnt_r - 6'd1)]};

  // shared multiplier with registered product
  logic [31:0] ma, mb;
  logic [63:0] prod_r;
  logic signed [16:0] err_r;
  logic [15:0] err_mag;
  logic [47:0] integ_mag;
  logic        ineg;
  logic [64:0] kp_term_r;
  logic [63:0] kilo_r;
  assign err_mag   = err_r[16] ? 16'(-err_r) : err_r[15:0];
  assign ineg      = integ_r[47];
  assign integ_mag = ineg ? 48'(-integ_r) : integ_r;

  always_comb begin
    ma = '0; mb = '0;
    if (cmd.integ_calc) begin ma = {{15{1'b0}}, err_mag, 1'b0} >> 1; mb = dt_r; end
    else if (cmd.kp_mul) begin ma = kp_r; mb = {16'd0, err_mag}; end
    else if (cmd.ki_lo_mul) begin ma = ki_r; mb = integ_mag[31:0]; end
    else begin ma = ki_r; mb = {16'd0, integ_mag[47:32]}; end
  end

  logic signed [49:0] acc_sum;
  logic signed [48:0] errdt;
  assign errdt   = err_r[16] ? -$signed({1'b0, prod_r[47:0]}) : $signed({1'b0, prod_r[47:0]});
  assign acc_sum = 50'(integ_r) + 50'(errdt);

  logic [64:0] ki_mag;
  logic signed [66:0] duty_sum;
  assign ki_mag   = 65'(prod_r) + 65'(ineg ? (kilo_r + 64'hFFFF_FFFF) >> 32 : kilo_r >> 32);

  always_ff @(posedge clk) begin
    prod_r <= 64'(ma) * 64'(mb);
    if (cmd.load) begin
      op_r <= in_op; sec_r <= sec_mod; now_r <= in_time_now;
      moved_r <= (diff != 3'd0);
      dvs_r <= in_time_now - prev_stime_r;
      dt_r  <= in_time_now - prev_ctime_r;
      rem_r <= '0; quo_r <= '0; dcnt_r <= 6'd32;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, dvs_r}); quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0]; quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.err_calc) err_r <= $signed({1'b0, target_r}) - $signed({1'b0, speed_r});
    if (cmd.kp_mul) kilo_r <= '0;
    if (cmd.ki_lo_mul)
      kp_term_r <= err_r[16] ? 65'((prod_r + 64'hFFFF) >> 16) : 65'(prod_r >> 16);
    if (cmd.ki_hi_mul) kilo_r <= prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sec_r <= '0; prev_stime_r <= '0; prev_ctime_r <= '0;
      speed_r <= '0; integ_r <= '0; duty_r <= '0; warm_r <= '0;
    end else begin
      if (cmd.comm_upd) begin
        prev_sec_r <= sec_r;
        if (moved_r) begin
          prev_stime_r <= now_r;
          speed_r <= (dvs_r == 32'd0 || quo_r > 32'd65535) ? 16'hFFFF : quo_r[15:0];
        end
      end
      if (cmd.tick_upd) begin
        prev_ctime_r <= now_r;
        if (warm_r < 3'(bldc_pkg::WarmupTicks)) warm_r <= warm_r + 3'd1;
      end
      if (cmd.integ_calc) begin
      end
      if (cmd.kp_mul) begin
        if (acc_sum > 50'sh7FFF_FFFF_FFFF) integ_r <= 48'h7FFF_FFFF_FFFF;
        else if (acc_sum < -50'sh8000_0000_0000) integ_r <= 48'h8000_0000_0000;
        else integ_r <= acc_sum[47:0];
      end
      if (cmd.duty_calc) begin
        if (duty_sum < 0) duty_r <= '0;
        else if (duty_sum > 67'sd32768) duty_r <= 16'd32768;
        else duty_r <= duty_sum[15:0];
      end
    end
  end

  assign duty_sum = (err_r[16] ? -$signed({2'b0, kp_term_r}) : $signed({2'b0, kp_term_r}))
                  + (ineg ? -$signed({2'b0, ki_mag}) : $signed({2'b0, ki_mag}));

  assign sts.is_tick  = op_r;
  assign sts.moved    = moved_r;
  assign sts.warm     = (warm_r >= 3'(bldc_pkg::WarmupTicks));
  assign sts.div_done = (dcnt_r == 6'd0);

  logic [2:0]  step;
  logic [23:0] pwm_full;
  assign step     = rev_r ? ((sec_r == 3'd0) ? 3'd5 : sec_r - 3'd1)
                          : ((sec_r == 3'd5) ? 3'd0 : sec_r + 3'd1);
  assign pwm_full = 24'(bldc_pkg::PwmMax) * {8'd0, duty_r};
  assign res_pwm  = pwm_full[22:15];
  assign res_drive = (!op_r && pwr_r) ? bldc_pkg::step_drive(step) : 3'b000;
  assign res_en    = (!op_r && pwr_r) ? bldc_pkg::step_enable(step) : 3'b000;
  assign res_speed = speed_r;
  assign res_duty  = duty_r;

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (dcnt_r == 6'd32))
    else $error("divider not armed");
  a_duty_rng: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= 16'd32768)
    else $error("duty out of range");
  a_warm_rng: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r <= 3'(bldc_pkg::WarmupTicks))
    else $error("warmup overrun");

endmodule

// ===== rtl/core/bldc_six_step_pi_speed_control.sv =====
// Six-step bldc commutation with a PI speed loop. Each accepted transaction
// yields one result. A commutation event whose sector moved waits on the
// one-bit-a-cycle speed divider; one with no move skips it. A PI tick after
// warmup uses the shared 32x32 multiplier for four products; during warmup
// it skips them. A result waits in the output register while the next
// transaction is taken. Depends on bldc_pkg, bldc_ctrl, bldc_dp.
module bldc_six_step_pi_speed_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [2:0]  in_hall_sector,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pwm_a,
  output logic [7:0]  out_pwm_b,
  output logic [7:0]  out_pwm_c,
  output logic        out_enable_a,
  output logic        out_enable_b,
  output logic        out_enable_c,
  output logic [15:0] out_speed_rpm,
  output logic [15:0] out_duty_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bldc_pkg::cmd_t    cmd;
  bldc_pkg::status_t sts;
  logic [7:0]  pwm;
  logic [2:0]  drv, en;
  logic [15:0] spd, duty;
  logic        out_free, out_valid_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  bldc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_free, .sts, .cmd
  );

  bldc_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_hall_sector, .in_time_now,
    .cfg_valid, .cfg_index, .cfg_data,
    .res_pwm(pwm), .res_drive(drv), .res_en(en), .res_speed(spd), .res_duty(duty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pwm_a <= drv[0] ? pwm : 8'd0;
      out_pwm_b <= drv[1] ? pwm : 8'd0;
      out_pwm_c <= drv[2] ? pwm : 8'd0;
      out_enable_a <= en[0];
      out_enable_b <= en[1];
      out_enable_c <= en[2];
      out_speed_rpm <= spd;
      out_duty_level <= duty;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== verif/bldc_speed_checker.sv =====
// result checker for the six-step bldc speed controller: watches the event,
// result and register channels, predicts each result and compares it
// depends on bldc_pkg
module bldc_speed_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [2:0]  in_hall_sector,
  input  logic [31:0] in_time_now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_pwm_a,
  input  logic [7:0]  out_pwm_b,
  input  logic [7:0]  out_pwm_c,
  input  logic        out_enable_a,
  input  logic        out_enable_b,
  input  logic        out_enable_c,
  input  logic [15:0] out_speed_rpm,
  input  logic [15:0] out_duty_level,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  pwm_a;
    logic [7:0]  pwm_b;
    logic [7:0]  pwm_c;
    logic        en_a;
    logic        en_b;
    logic        en_c;
    logic [15:0] speed;
    logic [15:0] duty;
  } drive_t;

  localparam longint IntegMax = 64'sd140737488355327;
  localparam longint IntegMin = -IntegMax - 1;

  drive_t drive_q[$];
  logic [31:0] kp, ki;
  logic [15:0] target;
  logic rev, pwr;
  logic [2:0] prev_hall, warm_cnt;
  logic [31:0] last_comm_time, last_tick_time;
  logic [15:0] speed_est, duty_reg;
  longint integ;

  // floor(g*v / 2^sh) for a non-negative gain and signed v
  function automatic longint gain_floor(logic [31:0] g, longint v, int sh);
    longint unsigned mag, hi, lo, r;
    mag = (v < 0) ? -v : v;
    if (sh == 16) begin
      r = longint'(g) * mag;
      return (v < 0) ? -longint'((r + 64'hFFFF) >> 16) : longint'(r >> 16);
    end
    hi = mag >> 32;
    lo = mag & 64'hFFFF_FFFF;
    r = longint'(g) * lo;
    if (v < 0) return -longint'(longint'(g) * hi + ((r + 64'hFFFF_FFFF) >> 32));
    return longint'(longint'(g) * hi + (r >> 32));
  endfunction

  function automatic drive_t predict_drive(logic op, logic [2:0] hall, logic [31:0] now);
    drive_t d;
    logic [2:0] sec, stp;
    logic [2:0] drv, ena;
    logic [31:0] el, dt;
    longint unsigned spd;
    longint err, acc, duty;
    logic [7:0] pwm;
    d = '0;
    sec = 3'(hall % 6);
    if (!op) begin
      if ((sec + 6 - prev_hall) % 6 != 0) begin
        el = now - last_comm_time;
        spd = 64'd65535;
        if (el != 0) begin
          spd = 64'd10000000 / el;
          if (spd > 64'd65535) spd = 64'd65535;
        end
        speed_est = spd[15:0];
        last_comm_time = now;
      end
      prev_hall = sec;
      stp = rev ? 3'((sec + 5) % 6) : 3'((sec + 1) % 6);
      if (pwr) begin
        pwm = 8'((64'd255 * duty_reg) >> 15);
        drv = bldc_pkg::step_drive(stp);
        ena = bldc_pkg::step_enable(stp);
        d.pwm_a = drv[0] ? pwm : 8'd0;
        d.pwm_b = drv[1] ? pwm : 8'd0;
        d.pwm_c = drv[2] ? pwm : 8'd0;
        {d.en_c, d.en_b, d.en_a} = ena;
      end
    end else begin
      dt = now - last_tick_time;
      last_tick_time = now;
      if (warm_cnt < bldc_pkg::WarmupTicks) begin
        warm_cnt = warm_cnt + 3'd1;
      end else begin
        err = longint'(target) - longint'(speed_est);
        acc = integ + err * longint'(dt);
        if (acc > IntegMax) acc = IntegMax;
        if (acc < IntegMin) acc = IntegMin;
        integ = acc;
        duty = gain_floor(kp, err, 16) + gain_floor(ki, acc, 32);
        if (duty < 0) duty = 0;
        if (duty > 32768) duty = 32768;
        duty_reg = duty[15:0];
      end
    end
    d.speed = speed_est;
    d.duty = duty_reg;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    drive_t e;
    if (!rst_n) begin
      kp <= 32'd77750; ki <= 32'd211120; target <= 16'd10000; rev <= 1'b0; pwr <= 1'b1;
      prev_hall = '0; last_comm_time = '0; last_tick_time = '0;
      speed_est = '0; duty_reg = '0; integ = 0; warm_cnt = '0;
      drive_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bldc_pkg::CFG_KP:      kp <= cfg_data;
          bldc_pkg::CFG_KI:      ki <= cfg_data;
          bldc_pkg::CFG_TARGET:  target <= cfg_data[15:0];
          bldc_pkg::CFG_REVERSE: rev <= cfg_data[0];
          bldc_pkg::CFG_POWER:   pwr <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_q.push_back(predict_drive(in_op, in_hall_sector, in_time_now));
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $display("%t: unexpected result transaction", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          e = drive_q.pop_front();
          if (e !== {out_pwm_a, out_pwm_b, out_pwm_c, out_enable_a, out_enable_b,
                     out_enable_c, out_speed_rpm, out_duty_level}) begin
            $display("%t: mismatch expected pwm %0d/%0d/%0d en %b%b%b spd %0d duty %0d",
                     $realtime, e.pwm_a, e.pwm_b, e.pwm_c, e.en_a, e.en_b, e.en_c,
                     e.speed, e.duty);
            $display("%t:          actual   pwm %0d/%0d/%0d en %b%b%b spd %0d duty %0d",
                     $realtime, out_pwm_a, out_pwm_b, out_pwm_c, out_enable_a,
                     out_enable_b, out_enable_c, out_speed_rpm, out_duty_level);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = drive_q.size();
endmodule

// ===== verif/bldc_six_step_pi_speed_control_test.sv =====
// stimulus and verdict for the six-step bldc speed controller
// depends on bldc_pkg, the block and bldc_speed_checker
module bldc_six_step_pi_speed_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, in_op;
  logic [2:0] in_hall_sector;
  logic [31:0] in_time_now;
  logic out_valid, out_stall;
  logic [7:0] out_pwm_a, out_pwm_b, out_pwm_c;
  logic out_enable_a, out_enable_b, out_enable_c;
  logic [15:0] out_speed_rpm, out_duty_level;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending_count, quiet_cycles;
  logic [31:0] clock_now;
  logic [2:0] rotor;

  bldc_six_step_pi_speed_control i_dut (.*);
  bldc_speed_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 3);
  endfunction

  // receiver stall pattern, varied in stretches
  initial begin
    int mode;
    out_stall = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 400)) begin
        @(negedge clk);
        out_stall <= (mode == 0) ? 1'b0 :
                     ($urandom_range(0, 29) == 0) ? 1'b1 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL bldc_six_step_pi_speed_control");
      $finish;
    end
  end

  // valid stays up after a transaction so the next one can follow at once
  task automatic send_event(logic op, logic [2:0] hall, logic [31:0] now, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_hall_sector <= hall;
    in_time_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // a rotor turning at a random rate with jitter and occasional jumps, plus pi ticks
  task automatic spin(int count);
    logic [31:0] period;
    period = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(100, 3000);
    repeat (count) begin
      clock_now += ($urandom_range(0, 9) == 0) ? $urandom : period + $urandom_range(0, 50);
      if ($urandom_range(0, 2) == 0) begin
        send_event(1'b1, 3'd0, clock_now, 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: rotor = 3'($urandom_range(0, 7));
          1: ;
          2: rotor = 3'((rotor % 6 + 5) % 6);
          default: rotor = 3'((rotor % 6 + 1) % 6);
        endcase
        send_event(1'b0, rotor, clock_now, 1'b1);
      end
    end
  endtask

  initial begin
    int i;
    in_valid = 0; in_op = 0; in_hall_sector = 0; in_time_now = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    clock_now = 0; rotor = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: warmup ticks, zero elapsed, sector wrap, sectors above five
    send_event(1'b0, 3'd0, 32'd0, 1'b0);
    send_event(1'b0, 3'd1, 32'd0, 1'b0);
    for (i = 0; i < 6; i++) send_event(1'b1, 3'd0, 32'd1000 * i, 1'b0);
    send_event(1'b0, 3'd2, 32'hFFFF_FFFF, 1'b0);
    send_event(1'b0, 3'd6, 32'd400, 1'b0);
    send_event(1'b0, 3'd7, 32'd400, 1'b0);
    send_event(1'b0, 3'd7, 32'd900, 1'b0);
    send_event(1'b1, 3'd3, 32'hFFFF_FFFF, 1'b0);
    send_event(1'b1, 3'd5, 32'd7000, 1'b0);
    for (i = 0; i < 6; i++) send_event(1'b0, 3'(i), 32'd8000 + 100 * i, 1'b0);
    drain();
    write_reg(bldc_pkg::CFG_REVERSE, 32'd1);
    write_reg(bldc_pkg::CFG_KP, 32'hFFFF_FFFF);
    write_reg(bldc_pkg::CFG_KI, 32'hFFFF_FFFF);
    write_reg(bldc_pkg::CFG_TARGET, 32'h0000_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_event(1'b1, 3'd0, 32'h8000_0000, 1'b0);
    send_event(1'b1, 3'd0, 32'h0, 1'b0);
    for (i = 0; i < 6; i++) send_event(1'b0, 3'(5 - i), 32'd100 * i, 1'b0);
    drain();
    write_reg(bldc_pkg::CFG_POWER, 32'd0);
    spin(10);
    drain();
    write_reg(bldc_pkg::CFG_POWER, 32'd1);
    write_reg(bldc_pkg::CFG_TARGET, 32'd0);
    write_reg(bldc_pkg::CFG_KP, 32'd0);
    write_reg(bldc_pkg::CFG_KI, 32'd0);
    spin(10);

    // random phases under varied settings
    for (int ph = 0; ph < 18; ph++) begin
      drain();
      case (ph % 3)
        0: write_reg(bldc_pkg::CFG_KP, $urandom_range(0, 300000));
        1: write_reg(bldc_pkg::CFG_KP, $urandom);
        default: write_reg(bldc_pkg::CFG_KP, 32'd77750);
      endcase
      write_reg(bldc_pkg::CFG_KI, (ph % 4 == 0) ? $urandom : $urandom_range(0, 1000000));
      write_reg(bldc_pkg::CFG_TARGET, (ph % 5 == 0) ? $urandom_range(0, 65535) :
                                      $urandom_range(0, 20000));
      write_reg(bldc_pkg::CFG_REVERSE, $urandom_range(0, 1));
      write_reg(bldc_pkg::CFG_POWER, 32'($urandom_range(0, 5) != 0));
      spin(100);
    end

    drain();
    if (fail_count == 0)
      $display("PASS bldc_six_step_pi_speed_control");
    else
      $display("FAIL bldc_six_step_pi_speed_control");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/bldc_pkg.sv
rtl/core/bldc_ctrl.sv
rtl/core/bldc_dp.sv
rtl/core/bldc_six_step_pi_speed_control.sv
verif/bldc_speed_checker.sv
verif/bldc_six_step_pi_speed_control_test.sv
